@@ hdl/wvr_pkg.sv @@
package wvr_pkg;

  localparam int DEPTH_DEF      = 512;
  localparam int PRICE_BITS_DEF = 24;

  localparam int STEP_BITS  = 6;
  localparam int WIN_BITS   = 9;
  localparam int STEP_MIN   = 2;
  localparam int STEP_MAX   = 32;
  localparam int STEP_RESET = 4;
  localparam int WIN_RESET  = 200;

  localparam int MIN_SAMPLES = 3;

  localparam int RATIO_BITS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_LENGTH   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = CFG_IDX_BITS'(1);

endpackage

@@ hdl/wvr_if.sv @@
interface wvr_in_if import wvr_pkg::*; #(
  parameter int PRICE_BITS = PRICE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] close_price;

  modport source (output valid, output close_price, input ready);
  modport sink (input valid, input close_price, output ready);
endinterface

interface wvr_out_if import wvr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [RATIO_BITS-1:0] ratio;

  modport source (output valid, output ratio, input ready);
  modport sink (input valid, input ratio, output ready);
endinterface

interface wvr_cfg_if import wvr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/wvr_div.sv @@
module wvr_div import wvr_pkg::*; #(
  parameter int ACC_W = 57
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ACC_W+STEP_BITS-1:0]     prod,
  input  logic [ACC_W-1:0]               den,
  output logic                           done,
  output logic [RATIO_BITS-1:0]          quot
);

  localparam int PROD_W = ACC_W + STEP_BITS;
  localparam int HI_W   = PROD_W - FRAC_BITS;
  localparam int CNT_W  = $clog2(RATIO_BITS + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [ACC_W-1:0]      rem_r;
  logic [RATIO_BITS-1:0] shf_r;
  logic [RATIO_BITS-1:0] q_r;

  logic [HI_W-1:0]  hi;
  logic             sat;
  logic [ACC_W:0]   trial;
  logic [ACC_W:0]   diff;
  logic             ge;

  assign hi    = prod[PROD_W-1:FRAC_BITS];
  assign sat   = ACC_W'(hi) >= den;
  assign trial = {rem_r, shf_r[RATIO_BITS-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= start ? sat : (busy_r && (cnt_r == CNT_W'(1)));
      if (start) begin
        if (sat) begin
          q_r    <= '1;
        end else begin
          rem_r  <= ACC_W'(hi);
          shf_r  <= {prod[FRAC_BITS-1:0], {(RATIO_BITS-FRAC_BITS){1'b0}}};
          q_r    <= '0;
          cnt_r  <= CNT_W'(RATIO_BITS);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
        shf_r <= {shf_r[RATIO_BITS-2:0], 1'b0};
        q_r   <= {q_r[RATIO_BITS-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ hdl/windowed_variance_ratio_unit.sv @@
// windowed variance ratio engine
// in_chan carries one close price per transfer; each price goes into a ring
// memory of DEPTH entries. out_chan carries at most one ratio per price:
// RV*m/RVm in unsigned Q16.16, saturated, 0 when RVm is 0. No ratio comes
// for the first two prices or while step_length is below two.
// cfg_chan writes step_length (index 0) and window_length (index 1); it is
// always ready and is meant to be written only while the engine is idle.
// The time from transfer to result is set by the single read port of the
// ring: one stored price is fetched per cycle, first for the one-step sum,
// then for the m-step sum, followed by a bit-serial divide. Prices that
// yield no result return to idle straight from the setup state.
// One price is processed at a time; in_chan is ready only while idle.
// A finished ratio sits in an output register, so a stalled receiver does
// not block the next price; the engine waits only when a second ratio is
// ready before the first has been taken.
// Reset clears the ring pointer and the sample count and loads the
// register defaults; the ring contents need no clearing.
module windowed_variance_ratio_unit import wvr_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int PRICE_BITS = PRICE_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  wvr_in_if.sink    in_chan,
  wvr_out_if.source out_chan,
  wvr_cfg_if.sink   cfg_chan
);

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int ACC_W   = 2 * PRICE_BITS + AW;
  localparam int PROD_W  = ACC_W + STEP_BITS;
  localparam int SW      = (CW > WIN_BITS ? CW : WIN_BITS) + 1;
  localparam int WIN_MAX = DEPTH - STEP_MAX - 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_RV,
    S_RV_DRAIN,
    S_RVM,
    S_RVM_DRAIN,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t                state_r;
  logic [STEP_BITS-1:0]  step_r;
  logic [WIN_BITS-1:0]   win_r;
  logic [AW-1:0]         wp_r;
  logic [CW-1:0]         sc_r;
  logic [AW-1:0]         back_r;
  logic                  first_r;
  logic [STEP_BITS-1:0]  m_r;
  logic [AW-1:0]         s_off_r;
  logic [ACC_W-1:0]      rv_r;
  logic [ACC_W-1:0]      rvm_r;
  logic [PROD_W-1:0]     prod_r;
  logic [RATIO_BITS-1:0] res_r;
  logic                  div_start_r;
  logic                  out_valid_r;
  logic [RATIO_BITS-1:0] out_ratio_r;

  logic [PRICE_BITS-1:0] ring [DEPTH];
  logic [PRICE_BITS-1:0] mem_q;

  logic                    rd_v_r;
  logic                    rd_first_r;
  logic [PRICE_BITS-1:0]   prev_r;
  logic                    dv_r;
  logic [PRICE_BITS-1:0]   diff_r;
  logic                    sv_r;
  logic [2*PRICE_BITS-1:0] sq_r;
  logic [ACC_W-1:0]        acc_r;

  logic                  in_xfer;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         newest;
  logic [AW:0]           addr_sum;
  logic [AW-1:0]         inc;
  logic                  last;
  logic                  pipe_empty;
  logic                  acc_clr;
  logic [STEP_BITS-1:0]  m_eff;
  logic [SW-1:0]         w_eff;
  logic [SW-1:0]         n_idx;
  logic                  full;
  logic                  wide_s;
  logic                  empty_sum;
  logic [SW-1:0]         s_off;
  logic                  div_done;
  logic [RATIO_BITS-1:0] div_q;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_xfer        = in_chan.valid && (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.ratio = out_ratio_r;

  // window start relative to the newest price
  always_comb begin
    m_eff     = (step_r > STEP_BITS'(STEP_MAX)) ? STEP_BITS'(STEP_MAX) : step_r;
    w_eff     = (SW'(win_r) > SW'(WIN_MAX)) ? SW'(WIN_MAX) : SW'(win_r);
    n_idx     = SW'(sc_r) - SW'(1);
    full      = (sc_r == CW'(DEPTH));
    wide_s    = full || (n_idx > w_eff + SW'(m_eff));
    empty_sum = !wide_s && (n_idx < SW'(m_eff));
    s_off     = wide_s ? w_eff : n_idx - SW'(m_eff);
  end

  // ring address of the price back_r steps before the newest
  always_comb begin
    newest   = (wp_r == '0) ? AW'(DEPTH - 1) : wp_r - AW'(1);
    addr_sum = {1'b0, newest} + (AW+1)'(DEPTH) - {1'b0, back_r};
    if (addr_sum >= (AW+1)'(DEPTH)) begin
      addr_sum = addr_sum - (AW+1)'(DEPTH);
    end
    rd_addr = addr_sum[AW-1:0];
  end

  assign rd_en      = (state_r == S_RV) || (state_r == S_RVM);
  assign inc        = (state_r == S_RV) ? AW'(1) : AW'(m_r);
  assign last       = back_r < inc;
  assign pipe_empty = !rd_v_r && !dv_r && !sv_r;
  assign acc_clr    = (state_r == S_SETUP) || ((state_r == S_RV_DRAIN) && pipe_empty);

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ring[wp_r] <= in_chan.close_price[PRICE_BITS-1:0];
    end
    if (rd_en) begin
      mem_q <= ring[rd_addr];
    end
  end

  // difference, square and accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      dv_r   <= 1'b0;
      sv_r   <= 1'b0;
    end else begin
      rd_v_r <= rd_en;
      dv_r   <= rd_v_r && !rd_first_r;
      sv_r   <= dv_r;
    end
    if (rd_en) begin
      rd_first_r <= first_r;
    end
    if (rd_v_r) begin
      prev_r <= mem_q;
    end
    diff_r <= (mem_q > prev_r) ? mem_q - prev_r : prev_r - mem_q;
    sq_r   <= (2*PRICE_BITS)'(diff_r) * (2*PRICE_BITS)'(diff_r);
    if (acc_clr) begin
      acc_r <= '0;
    end else if (sv_r) begin
      acc_r <= acc_r + ACC_W'(sq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_BITS'(STEP_RESET);
      win_r       <= WIN_BITS'(WIN_RESET);
      wp_r        <= '0;
      sc_r        <= '0;
      first_r     <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          CFG_STEP_LENGTH:   step_r <= cfg_chan.data[STEP_BITS-1:0];
          CFG_WINDOW_LENGTH: win_r  <= cfg_chan.data[WIN_BITS-1:0];
          default: ;
        endcase
      end

      if ((state_r == S_FIN) && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      div_start_r <= (state_r == S_MUL);

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
            if (sc_r != CW'(DEPTH)) begin
              sc_r <= sc_r + CW'(1);
            end
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (sc_r < CW'(MIN_SAMPLES) || step_r < STEP_BITS'(STEP_MIN)) begin
            state_r <= S_IDLE;
          end else if (empty_sum) begin
            res_r   <= '0;
            state_r <= S_FIN;
          end else begin
            m_r     <= m_eff;
            s_off_r <= AW'(s_off);
            back_r  <= AW'(s_off) + AW'(1);
            first_r <= 1'b1;
            state_r <= S_RV;
          end
        end
        S_RV: begin
          first_r <= 1'b0;
          if (last) begin
            state_r <= S_RV_DRAIN;
          end else begin
            back_r <= back_r - inc;
          end
        end
        S_RV_DRAIN: begin
          if (pipe_empty) begin
            rv_r    <= acc_r;
            back_r  <= s_off_r + AW'(m_r);
            first_r <= 1'b1;
            state_r <= S_RVM;
          end
        end
        S_RVM: begin
          first_r <= 1'b0;
          if (last) begin
            state_r <= S_RVM_DRAIN;
          end else begin
            back_r <= back_r - inc;
          end
        end
        S_RVM_DRAIN: begin
          if (pipe_empty) begin
            if (acc_r == '0) begin
              res_r   <= '0;
              state_r <= S_FIN;
            end else begin
              rvm_r   <= acc_r;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(rv_r) * PROD_W'(m_r);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_r   <= div_q;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_chan.ready) begin
            out_ratio_r <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  wvr_div #(
    .ACC_W (ACC_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .prod  (prod_r),
    .den   (rvm_r),
    .done  (div_done),
    .quot  (div_q)
  );

endmodule
